>>> sv/owned_rectangle_hit_table_defines.svh
// ----------------------------------------------------------------------------
// owned rectangle hit table assertion macros
// shared concurrent checks, clocked on i_clk and held off during reset
// ----------------------------------------------------------------------------
`ifndef OWNED_RECTANGLE_HIT_TABLE_DEFINES_SVH
`define OWNED_RECTANGLE_HIT_TABLE_DEFINES_SVH

// consequent must hold in the same cycle
`define ORHT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ORHT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/orht_pkg.sv
// ----------------------------------------------------------------------------
// orht_pkg
// codes and shared types of the owned rectangle hit table
// ----------------------------------------------------------------------------
package orht_pkg;

    // item kinds
    localparam logic [1:0] K_DEFINE = 2'd0;
    localparam logic [1:0] K_HIT    = 2'd1;
    localparam logic [1:0] K_CLEAR  = 2'd2;

    // result status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // command held steady while a token walks the chain
    typedef struct packed {
        logic [1:0]         kind;
        logic [15:0]        owner;
        logic [15:0]        button_id;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [15:0]        rect_width;
        logic [15:0]        rect_height;
    } t_cmd;

    // token handed from cell to cell
    typedef struct packed {
        logic        valid;
        logic        fill;       // second pass: claim lowest free entry
        logic        done;       // entry matched, hit found or fill placed
        logic        free_seen;  // some free entry passed during define scan
        logic [15:0] hit_id;
    } t_tok;

endpackage

>>> sv/orht_ifs.sv
// ----------------------------------------------------------------------------
// orht interfaces
// valid/ready channels for request and response beats
// ----------------------------------------------------------------------------
interface orht_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [15:0]        owner;
    logic [15:0]        button_id;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        rect_width;
    logic [15:0]        rect_height;

    modport source (
        output valid, kind, owner, button_id, pos_x, pos_y, rect_width, rect_height,
        input  ready
    );
    modport sink (
        input  valid, kind, owner, button_id, pos_x, pos_y, rect_width, rect_height,
        output ready
    );
endinterface

interface orht_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] hit_id;

    modport source (
        output valid, status, hit_id,
        input  ready
    );
    modport sink (
        input  valid, status, hit_id,
        output ready
    );
endinterface

>>> sv/orht_cell.sv
// ----------------------------------------------------------------------------
// orht_cell
// one table entry; acts on the passing token and registers it onward
// ----------------------------------------------------------------------------
module orht_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  orht_pkg::t_cmd i_cmd,
    input  orht_pkg::t_tok i_tok,
    output orht_pkg::t_tok o_tok
);
    import orht_pkg::*;

    logic               r_used, n_used;
    logic [15:0]        r_owner, n_owner;
    logic [15:0]        r_ident;
    logic signed [15:0] r_left;
    logic signed [15:0] r_top;
    logic [15:0]        r_wide;
    logic [15:0]        r_tall;
    t_tok               r_tok, n_tok;

    logic               w_wr;
    logic               w_own_eq;
    logic               w_inside;
    logic signed [17:0] w_px, w_py, w_lft, w_tp, w_rgt, w_bot;

    assign w_own_eq = (r_owner == i_cmd.owner);

    // half-open box test at widened width
    assign w_px  = 18'(i_cmd.pos_x);
    assign w_py  = 18'(i_cmd.pos_y);
    assign w_lft = 18'(r_left);
    assign w_tp  = 18'(r_top);
    assign w_rgt = w_lft + $signed({2'b00, r_wide});
    assign w_bot = w_tp + $signed({2'b00, r_tall});
    assign w_inside = (w_px >= w_lft) && (w_py >= w_tp) && (w_px < w_rgt) && (w_py < w_bot);

    always_comb begin
        n_tok   = i_tok;
        n_used  = r_used;
        n_owner = r_owner;
        w_wr    = 1'b0;
        if (i_tok.valid) begin
            unique case (i_cmd.kind)
                K_DEFINE: begin
                    if (i_tok.fill) begin
                        w_wr = !r_used && !i_tok.done;
                    end else begin
                        w_wr = r_used && w_own_eq && (r_ident == i_cmd.button_id)
                               && !i_tok.done;
                        if (!r_used) begin
                            n_tok.free_seen = 1'b1;
                        end
                    end
                    if (w_wr) begin
                        n_tok.done = 1'b1;
                        n_used     = 1'b1;
                        n_owner    = i_cmd.owner;
                    end
                end
                K_HIT: begin
                    if (r_used && w_own_eq && w_inside && !i_tok.done) begin
                        n_tok.done   = 1'b1;
                        n_tok.hit_id = r_ident;
                    end
                end
                K_CLEAR: begin
                    if (w_own_eq) begin
                        n_used  = 1'b0;
                        n_owner = 16'd0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= 1'b0;
            r_owner   <= 16'd0;
            r_tok     <= '0;
        end else begin
            r_used    <= n_used;
            r_owner   <= n_owner;
            r_tok     <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_ident <= i_cmd.button_id;
            r_left  <= i_cmd.pos_x;
            r_top   <= i_cmd.pos_y;
            r_wide  <= i_cmd.rect_width;
            r_tall  <= i_cmd.rect_height;
        end
    end

    assign o_tok = r_tok;

endmodule

>>> sv/owned_rectangle_hit_table.sv
// ----------------------------------------------------------------------------
// owned rectangle hit table
// table of owned rectangles with define, clear and hit-test commands
// ----------------------------------------------------------------------------
// The table is a row of ENTRIES cells, one entry each, and every request beat
// that needs a pass sends a token down the row, one cell per clock, while the
// command is held in a register seen by all cells. Hit, clear, a define that
// updates an existing entry and a define that finds the table full each take
// one pass. A define that adds a new entry needs a second pass to claim the
// lowest free cell. Invalid defines and unused kinds launch no token and go
// straight to the result state. One request is in flight at a time; the
// response register lets the next request in while the last response waits.
// Used bits and owners clear at reset.
// ----------------------------------------------------------------------------
`include "owned_rectangle_hit_table_defines.svh"

module owned_rectangle_hit_table #(
    parameter int ENTRIES = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    orht_req_if.sink     i_req,
    orht_rsp_if.source   o_rsp
);
    import orht_pkg::*;

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;  // ready for a request beat
    localparam logic [1:0] S_SCAN = 2'd1;  // token walking the row
    localparam logic [1:0] S_FILL = 2'd2;  // second pass placing a new entry
    localparam logic [1:0] S_POST = 2'd3;  // result ready for the response register

    logic [1:0]  r_state, n_state;
    t_cmd        r_cmd, n_cmd;
    t_tok        r_launch, n_launch;
    logic [1:0]  r_res_status, n_res_status;
    logic [15:0] r_res_hit, n_res_hit;
    logic        r_out_valid, n_out_valid;
    logic [1:0]  r_out_status, n_out_status;
    logic [15:0] r_out_hit, n_out_hit;

    t_tok        w_tok [0:ENTRIES];
    t_tok        w_tail;
    logic        w_accept;
    logic        w_bad_define;

    // token enters the first cell from the launch register
    assign w_tok[0] = r_launch;
    assign w_tail   = w_tok[ENTRIES];

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            orht_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cmd   (r_cmd),
                .i_tok   (w_tok[g]),
                .o_tok   (w_tok[g+1])
            );
        end
    endgenerate

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    // a define with zero owner, id, width or height is refused before any cell sees it
    assign w_bad_define = (i_req.owner == 16'd0) || (i_req.button_id == 16'd0) ||
                          (i_req.rect_width == 16'd0) || (i_req.rect_height == 16'd0);

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_launch     = '0;
        n_res_status = r_res_status;
        n_res_hit    = r_res_hit;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_hit    = r_out_hit;

        // response register drains independently of the sequencer
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd.kind        = i_req.kind;
                    n_cmd.owner       = i_req.owner;
                    n_cmd.button_id   = i_req.button_id;
                    n_cmd.pos_x       = i_req.pos_x;
                    n_cmd.pos_y       = i_req.pos_y;
                    n_cmd.rect_width  = i_req.rect_width;
                    n_cmd.rect_height = i_req.rect_height;
                    n_res_status      = ST_OK;
                    n_res_hit         = 16'd0;
                    if ((i_req.kind == K_DEFINE) && w_bad_define) begin
                        n_res_status = ST_INVALID;
                        n_state      = S_POST;
                    end else if ((i_req.kind == K_DEFINE) || (i_req.kind == K_HIT) ||
                                 (i_req.kind == K_CLEAR)) begin
                        n_launch.valid = 1'b1;
                        n_state        = S_SCAN;
                    end else begin
                        // unused kind: plain ok beat
                        n_state = S_POST;
                    end
                end
            end
            S_SCAN: begin
                if (w_tail.valid) begin
                    n_state = S_POST;
                    if (r_cmd.kind == K_DEFINE) begin
                        if (w_tail.done) begin
                            n_res_status = ST_OK;        // existing entry updated
                        end else if (w_tail.free_seen) begin
                            n_launch.valid = 1'b1;       // go claim the lowest free cell
                            n_launch.fill  = 1'b1;
                            n_state        = S_FILL;
                        end else begin
                            n_res_status = ST_FULL;
                        end
                    end else if (r_cmd.kind == K_HIT) begin
                        n_res_hit = w_tail.hit_id;
                    end
                end
            end
            S_FILL: begin
                if (w_tail.valid) begin
                    n_res_status = ST_OK;
                    n_state      = S_POST;
                end
            end
            S_POST: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_hit    = r_res_hit;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_launch    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_launch    <= n_launch;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_res_status <= n_res_status;
        r_res_hit    <= n_res_hit;
        r_out_status <= n_out_status;
        r_out_hit    <= n_out_hit;
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_out_status;
    assign o_rsp.hit_id = r_out_hit;

    // a token reaches the end of the row only while a pass is running
    `ORHT_ASSERT_NOW(a_tail_in_pass, w_tail.valid, (r_state == S_SCAN) || (r_state == S_FILL), "token left the row outside a pass")
    // the fill pass starts only after a free cell was seen, so it must land
    `ORHT_ASSERT_NOW(a_fill_lands, w_tail.valid && (r_state == S_FILL), w_tail.done, "fill pass found no free cell")
    // a nonzero hit id only ever comes with ok status
    `ORHT_ASSERT_NOW(a_hit_status, r_out_valid && (r_out_hit != 16'd0), r_out_status == ST_OK, "hit id with error status")
    // a define with zero owner is refused without a pass
    `ORHT_ASSERT_NEXT(a_bad_owner, w_accept && (i_req.kind == K_DEFINE) && (i_req.owner == 16'd0), (r_state == S_POST) && (r_res_status == ST_INVALID), "zero-owner define not refused")
    // every accepted beat either launches a token or goes straight to the result
    `ORHT_ASSERT_NEXT(a_accept_moves, w_accept, r_launch.valid || (r_state == S_POST), "request beat neither launched nor answered")

endmodule
